FILE: design/assert_macros.svh
// Assertion macros shared by the keypad scanner RTL.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keypad scanner assertion failed");
`define KD_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("keypad scanner forbidden condition seen");
`else
`define KD_ASSERT(name, clk, rst_n, prop)
`define KD_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

FILE: design/mkds_pkg.sv
// Package for the matrix keypad debounce scanner: register indexes,
// reset values and fixed field widths. No dependencies.
`default_nettype none
package mkds_pkg;

  localparam int unsigned DEF_MAX_ROWS = 6;
  localparam int unsigned DEF_MAX_COLS = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIM_W      = 3;
  localparam int unsigned CNT_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT   = 2'd3;

  localparam logic [DIM_W-1:0] RST_ROW_COUNT    = 3'd4;
  localparam logic [DIM_W-1:0] RST_COL_COUNT    = 3'd4;
  localparam logic             RST_PRESSED_HIGH = 1'b1;
  localparam logic [CNT_W-1:0] RST_HOLD_COUNT   = 8'd200;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage
`default_nettype wire

FILE: design/matrix_keypad_debounce_scan_top.sv
// Matrix keypad scanner with per-key debounce; one module holding the
// counter memory and the walk. Depends on mkds_pkg and assert_macros.svh.
//
// Each request on the slave stream is one sample of the key matrix (bit
// row*MAX_COLS+col per key). The block walks the configured keys in row-major
// order, one hold counter per cycle through a counter memory with one read
// and one write port (registered read, with the new count written back in
// the cycle after the read), and returns exactly one result: the 1-based
// code, row and column of the first key whose counter reaches hold_count, or
// all zeros. Keys after the reported one are left untouched. An item occupies
// the block, one counter read per key, until its result is loaded into the
// output register, which waits while the previous result is still held
// there; no new sample is taken before that. Counters start at zero after
// reset through per-entry valid flags, so no clearing pass is needed. The
// next sample is taken while a result still waits on the master stream.
`default_nettype none
`include "assert_macros.svh"
module matrix_keypad_debounce_scan_top #(
  parameter int unsigned MAX_ROWS = mkds_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = mkds_pkg::DEF_MAX_COLS,
  localparam int unsigned KEY_SLOTS = MAX_ROWS * MAX_COLS,
  localparam int unsigned TD_IN_W   = ((KEY_SLOTS + 7) / 8) * 8,
  localparam int unsigned CODE_W    = $clog2(KEY_SLOTS + 1),
  localparam int unsigned ROW_W     = $clog2(MAX_ROWS + 1),
  localparam int unsigned COL_W     = $clog2(MAX_COLS + 1),
  localparam int unsigned OUT_W     = CODE_W + ROW_W + COL_W,
  localparam int unsigned TD_OUT_W  = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mkds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mkds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [TD_IN_W-1:0]             s_axis_tdata_i,  // key_levels
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [TD_OUT_W-1:0]                 m_axis_tdata_o   // key_code, key_row, key_col
);

  localparam int unsigned SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] COLS_C = SLOT_W'(MAX_COLS);
  localparam logic [3:0] MAX_ROWS_C = 4'(MAX_ROWS);
  localparam logic [3:0] MAX_COLS_C = 4'(MAX_COLS);

  typedef logic [mkds_pkg::DIM_W-1:0] dim_t;
  typedef logic [mkds_pkg::CNT_W-1:0] cnt_t;

  // configuration registers
  dim_t row_count_q, col_count_q;
  logic pressed_high_q;
  cnt_t hold_count_q;

  mkds_pkg::state_e state_q;

  logic [KEY_SLOTS-1:0] levels_q;
  dim_t                 row_q, col_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 issue_q;

  logic                 s1_vld_q, s1_last_q, s1_pressed_q;
  dim_t                 s1_row_q, s1_col_q;
  logic [SLOT_W-1:0]    s1_slot_q;

  cnt_t                 mem_q [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] slot_valid_q;
  cnt_t                 rd_data_q;
  logic                 rd_valid_q;

  logic [CODE_W-1:0]    res_code_q, out_code_q;
  logic [ROW_W-1:0]     res_row_q, out_row_q;
  logic [COL_W-1:0]     res_col_q, out_col_q;
  logic                 out_valid_q;

  dim_t              rows_eff, cols_eff;
  logic [SLOT_W-1:0] lvl_idx;
  logic              cur_pressed, cur_last, col_wrap;
  logic              in_accept, rd_en, wr_en, hit, out_load;
  cnt_t              cnt_cur, cnt_next;

  // counts above the matrix size fall back to the maximum
  assign rows_eff = ({1'b0, row_count_q} > MAX_ROWS_C) ? dim_t'(MAX_ROWS) : row_count_q;
  assign cols_eff = ({1'b0, col_count_q} > MAX_COLS_C) ? dim_t'(MAX_COLS) : col_count_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == mkds_pkg::S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign lvl_idx     = SLOT_W'(row_q) * COLS_C + SLOT_W'(col_q);
  assign cur_pressed = (levels_q[lvl_idx] == pressed_high_q);
  assign col_wrap    = (col_q == cols_eff - dim_t'(1));
  assign cur_last    = col_wrap && (row_q == rows_eff - dim_t'(1));

  assign rd_en = (state_q == mkds_pkg::S_WALK) && issue_q;
  assign wr_en = (state_q == mkds_pkg::S_WALK) && s1_vld_q;

  // saturating hold counter update
  always_comb begin
    cnt_cur = rd_valid_q ? rd_data_q : '0;
    if (!s1_pressed_q) begin
      cnt_next = '0;
    end else if (cnt_cur <= hold_count_q && cnt_cur != mkds_pkg::CNT_MAX) begin
      cnt_next = cnt_cur + cnt_t'(1);
    end else begin
      cnt_next = cnt_cur;
    end
  end
  assign hit = (cnt_next == hold_count_q);

  assign out_load = (state_q == mkds_pkg::S_DONE) && (!out_valid_q || m_axis_tready_i);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= mkds_pkg::RST_ROW_COUNT;
      col_count_q    <= mkds_pkg::RST_COL_COUNT;
      pressed_high_q <= mkds_pkg::RST_PRESSED_HIGH;
      hold_count_q   <= mkds_pkg::RST_HOLD_COUNT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mkds_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i[mkds_pkg::DIM_W-1:0];
        mkds_pkg::REG_COL_COUNT:    col_count_q    <= cfg_data_i[mkds_pkg::DIM_W-1:0];
        mkds_pkg::REG_PRESSED_HIGH: pressed_high_q <= cfg_data_i[0];
        mkds_pkg::REG_HOLD_COUNT:   hold_count_q   <= cfg_data_i;
      endcase
    end
  end

  // counter memory: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q  <= mem_q[slot_q];
      rd_valid_q <= slot_valid_q[slot_q];
    end
    if (wr_en) begin
      mem_q[s1_slot_q] <= cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (wr_en) begin
      slot_valid_q[s1_slot_q] <= 1'b1;
    end
  end

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mkds_pkg::S_IDLE;
      issue_q  <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        mkds_pkg::S_IDLE: begin
          if (in_accept) begin
            s1_vld_q <= 1'b0;
            if (rows_eff == '0 || cols_eff == '0) begin
              issue_q <= 1'b0;
              state_q <= mkds_pkg::S_DONE;
            end else begin
              issue_q <= 1'b1;
              state_q <= mkds_pkg::S_WALK;
            end
          end
        end
        mkds_pkg::S_WALK: begin
          // stop on a hit or at the last key; on a hit the read already in flight is dropped
          if (s1_vld_q && (hit || s1_last_q)) begin
            issue_q  <= 1'b0;
            s1_vld_q <= 1'b0;
            state_q  <= mkds_pkg::S_DONE;
          end else begin
            s1_vld_q <= issue_q;
            if (issue_q && cur_last) begin
              issue_q <= 1'b0;
            end
          end
        end
        mkds_pkg::S_DONE: begin
          if (out_load) begin
            state_q <= mkds_pkg::S_IDLE;
          end
        end
        default: state_q <= mkds_pkg::S_IDLE;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      levels_q  <= s_axis_tdata_i[KEY_SLOTS-1:0];
      row_q     <= '0;
      col_q     <= '0;
      slot_q    <= '0;
      res_code_q <= '0;
      res_row_q  <= '0;
      res_col_q  <= '0;
    end else if (rd_en) begin
      slot_q <= slot_q + SLOT_W'(1);
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_q + dim_t'(1);
      end else begin
        col_q <= col_q + dim_t'(1);
      end
    end
    if (rd_en) begin
      s1_row_q     <= row_q;
      s1_col_q     <= col_q;
      s1_slot_q    <= slot_q;
      s1_pressed_q <= cur_pressed;
      s1_last_q    <= cur_last;
    end
    if (wr_en && hit) begin
      res_code_q <= CODE_W'(s1_slot_q) + CODE_W'(1);
      res_row_q  <= ROW_W'(s1_row_q) + ROW_W'(1);
      res_col_q  <= COL_W'(s1_col_q) + COL_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= res_code_q;
      out_row_q  <= res_row_q;
      out_col_q  <= res_col_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TD_OUT_W'({out_col_q, out_row_q, out_code_q});

  `KD_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `KD_ASSERT(a_write_in_walk, clk_i, rst_ni, wr_en |-> state_q == mkds_pkg::S_WALK)
  `KD_ASSERT(a_done_emits, clk_i, rst_ni, out_load |=> m_axis_tvalid_o)
  `KD_ASSERT(a_code_has_pos, clk_i, rst_ni,
    (m_axis_tvalid_o && out_code_q != '0) |-> (out_row_q != '0 && out_col_q != '0))

endmodule
`default_nettype wire
